@@ rtl/eih_pkg.sv @@
// shared types and constants of the exponential interval histogram unit
`default_nettype none
package eih_pkg;
    localparam int FRAC_BITS = 24;
    localparam int SQ_STEPS  = 24;
    localparam int NORM_STEPS = 5;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] MEAN_RESET = 32'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SQUARE,
        S_LNMUL,
        S_IVMUL,
        S_READ,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       norm;
        logic [2:0] step;
        logic       square;
        logic       ln_mul;
        logic       iv_mul;
        logic       ram_rd;
        logic       update;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/eih_ifs.sv @@
// channel interfaces of the exponential interval histogram unit
`default_nettype none
interface eih_in_if #(parameter int UNIFORM_BITS = 16);
    logic                    valid;
    logic                    ready;
    logic [UNIFORM_BITS-1:0] uniform_code;
    modport source (output valid, output uniform_code, input ready);
    modport sink (input valid, input uniform_code, output ready);
endinterface

interface eih_out_if;
    logic        valid;
    logic        ready;
    logic [35:0] interval;
    logic [4:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] largest_count;
    logic [31:0] samples_seen;
    logic [62:0] interval_total;
    modport source (output valid, output interval, output bin_index, output bin_count,
                    output largest_count, output samples_seen, output interval_total,
                    input ready);
    modport sink (input valid, input interval, input bin_index, input bin_count,
                  input largest_count, input samples_seen, input interval_total,
                  output ready);
endinterface

interface eih_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/exponential_interval_histogram_unit.sv @@
// top level: uniform code to exponential interval with running histogram
// sequence from input beat to result valid: 5 normalize steps, 24 squaring
// steps of the log2 unit, ln2 multiply, mean multiply, bin read, bin update
// a new item is taken only after the bin update of the last one is done
// a finished result waits in the output register while the next item runs
// synchronous active-low reset clears bins, peak, sample count, sum; mean = 1.0
`default_nettype none
module exponential_interval_histogram_unit
    import eih_pkg::*;
#(
    parameter int NUM_BINS     = 25,
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    eih_in_if.sink     i_in,
    eih_cfg_if.sink    i_cfg,
    eih_out_if.source  o_out
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    eih_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    eih_dpath #(.NUM_BINS(NUM_BINS), .UNIFORM_BITS(UNIFORM_BITS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_code          (i_in.uniform_code),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_interval      (o_out.interval),
        .o_bin_index     (o_out.bin_index),
        .o_bin_count     (o_out.bin_count),
        .o_largest_count (o_out.largest_count),
        .o_samples_seen  (o_out.samples_seen),
        .o_interval_total(o_out.interval_total)
    );
endmodule
`default_nettype wire

@@ rtl/eih_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module eih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/eih_ctrl.sv @@
// sequencing state machine of the exponential interval histogram unit
`default_nettype none
module eih_ctrl
    import eih_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                o_cmd.step = r_cnt[2:0];
                if (r_cnt == 5'(NORM_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SQUARE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                if (r_cnt == 5'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LNMUL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_LNMUL: begin
                o_cmd.ln_mul = 1'b1;
                n_state      = S_IVMUL;
            end
            S_IVMUL: begin
                o_cmd.iv_mul = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/eih_dpath.sv @@
// log, multiply and histogram datapath of the exponential interval histogram unit
`default_nettype none
module eih_dpath
    import eih_pkg::*;
#(
    parameter int NUM_BINS     = 25,
    parameter int UNIFORM_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_sts                         o_sts,
    input  wire logic [UNIFORM_BITS-1:0] i_code,
    input  wire logic                    i_cfg_we,
    input  wire logic [31:0]             i_cfg_data,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic [35:0]                  o_interval,
    output logic [4:0]                   o_bin_index,
    output logic [31:0]                  o_bin_count,
    output logic [31:0]                  o_largest_count,
    output logic [31:0]                  o_samples_seen,
    output logic [62:0]                  o_interval_total
);
    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [29:0] N_BASE = 30'(UNIFORM_BITS) << FRAC_BITS;
    localparam logic [8:0]  BIN_TOP = 9'(NUM_BINS - 1);
    localparam logic [31:0] CNT_MAX = '1;
    localparam logic [62:0] TOTAL_MAX = '1;

    logic [31:0] r_mean;
    logic [31:0] r_m;
    logic [5:0]  r_e;
    logic [23:0] r_frac;
    logic [29:0] r_l;
    logic [35:0] r_iv;
    logic [8:0]  r_bin;
    logic        r_rd_vld;
    logic [NUM_BINS-1:0] r_vld;
    logic [31:0] r_peak;
    logic [31:0] r_samples;
    logic [62:0] r_total;
    logic        r_o_valid;
    logic [35:0] r_o_interval;
    logic [4:0]  r_o_bin;
    logic [31:0] r_o_count;

    logic [32:0] xn;
    logic [63:0] sq;
    logic [29:0] nval;
    logic [63:0] lnprod;
    logic [61:0] ivprod;
    logic [37:0] ivr;
    logic [32:0] bin5;
    logic [8:0]  bin_raw;
    logic [31:0] rd_data;
    logic [31:0] cur_cnt;
    logic [31:0] new_cnt;
    logic [63:0] sum;
    logic [BW-1:0] addr;

    assign xn      = 33'(i_code) + 33'd1;
    assign sq      = 64'(r_m) * 64'(r_m);
    assign nval    = N_BASE - {r_e, r_frac};
    assign lnprod  = 64'(nval) * 64'(LN2_Q32) + 64'h8000_0000;
    assign ivprod  = 62'(r_mean) * 62'(r_l) + 62'h80_0000;
    assign ivr     = ivprod[61:24];
    assign bin5    = 33'(r_l) * 33'd5;
    assign bin_raw = bin5[32:24];
    assign addr    = r_bin[BW-1:0];
    assign cur_cnt = r_rd_vld ? rd_data : '0;
    assign new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 32'd1;
    assign sum     = 64'(r_total) + 64'(r_iv);
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    eih_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_bins (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_re   (i_cmd.ram_rd),
        .i_addr (addr),
        .i_wdata(new_cnt),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frac <= '0;
            if (xn[32]) begin
                r_m <= 32'h8000_0000;
                r_e <= 6'd32;
            end else begin
                r_m <= xn[31:0];
                r_e <= 6'd31;
            end
        end
        if (i_cmd.norm) begin
            case (i_cmd.step)
                3'd0: if (r_m[31:16] == '0) begin
                    r_m <= r_m << 16;
                    r_e <= r_e - 6'd16;
                end
                3'd1: if (r_m[31:24] == '0) begin
                    r_m <= r_m << 8;
                    r_e <= r_e - 6'd8;
                end
                3'd2: if (r_m[31:28] == '0) begin
                    r_m <= r_m << 4;
                    r_e <= r_e - 6'd4;
                end
                3'd3: if (r_m[31:30] == '0) begin
                    r_m <= r_m << 2;
                    r_e <= r_e - 6'd2;
                end
                default: if (!r_m[31]) begin
                    r_m <= r_m << 1;
                    r_e <= r_e - 6'd1;
                end
            endcase
        end
        if (i_cmd.square) begin
            r_m    <= sq[63] ? sq[63:32] : sq[62:31];
            r_frac <= {r_frac[22:0], sq[63]};
        end
        if (i_cmd.ln_mul) begin
            r_l <= lnprod[61:32];
        end
        if (i_cmd.iv_mul) begin
            r_iv  <= (ivr[37:36] != 2'b00) ? '1 : ivr[35:0];
            r_bin <= (bin_raw > BIN_TOP) ? BIN_TOP : bin_raw;
        end
        if (i_cmd.ram_rd) begin
            r_rd_vld <= r_vld[addr];
        end
        if (i_cmd.update) begin
            r_o_interval <= r_iv;
            r_o_bin      <= r_bin[4:0];
            r_o_count    <= new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean    <= MEAN_RESET;
            r_vld     <= '0;
            r_peak    <= '0;
            r_samples <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mean <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_vld[addr] <= 1'b1;
                if (new_cnt > r_peak) begin
                    r_peak <= new_cnt;
                end
                if (r_samples != CNT_MAX) begin
                    r_samples <= r_samples + 32'd1;
                end
                r_total   <= sum[63] ? TOTAL_MAX : sum[62:0];
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_interval       = r_o_interval;
    assign o_bin_index      = r_o_bin;
    assign o_bin_count      = r_o_count;
    assign o_largest_count  = r_peak;
    assign o_samples_seen   = r_samples;
    assign o_interval_total = r_total;
endmodule
`default_nettype wire
